FILE: rtl/jts_pkg.sv
// ----------------------------------------------------------------------------
// jts_pkg
// Shared types, character codes, token kinds and word tables for the JSON
// token scanner.
// ----------------------------------------------------------------------------
package jts_pkg;

    localparam int OFFSET_BITS = 20;

    typedef logic [OFFSET_BITS-1:0] t_off;
    typedef logic [3:0]             t_kind;

    localparam t_off OFF_MAX = {OFFSET_BITS{1'b1}};

    // token kinds
    localparam t_kind K_LBRACE   = 4'd0;
    localparam t_kind K_RBRACE   = 4'd1;
    localparam t_kind K_COLON    = 4'd2;
    localparam t_kind K_COMMA    = 4'd3;
    localparam t_kind K_DOT      = 4'd4;
    localparam t_kind K_LBRACKET = 4'd5;
    localparam t_kind K_RBRACKET = 4'd6;
    localparam t_kind K_STRING   = 4'd7;
    localparam t_kind K_NUMBER   = 4'd8;
    localparam t_kind K_BOOL     = 4'd9;
    localparam t_kind K_NULL     = 4'd10;
    localparam t_kind K_BADCHAR  = 4'd11;
    localparam t_kind K_UNKNOWN  = 4'd12;
    localparam t_kind K_UNTERM   = 4'd13;

    // scan modes
    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_INT  = 3'd1;
    localparam logic [2:0] MODE_DOT  = 3'd2;
    localparam logic [2:0] MODE_FRAC = 3'd3;
    localparam logic [2:0] MODE_EXP  = 3'd4;
    localparam logic [2:0] MODE_STR  = 3'd5;
    localparam logic [2:0] MODE_ESC  = 3'd6;
    localparam logic [2:0] MODE_WORD = 3'd7;

    // word candidates
    localparam logic [1:0] CAND_NONE  = 2'd0;
    localparam logic [1:0] CAND_TRUE  = 2'd1;
    localparam logic [1:0] CAND_FALSE = 2'd2;
    localparam logic [1:0] CAND_NULL  = 2'd3;

    // characters
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_SP       = 8'h20;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_E        = 8'h65;
    localparam logic [7:0] CH_UNDER    = 8'h5F;
    localparam logic [7:0] CH_T        = 8'h74;
    localparam logic [7:0] CH_F        = 8'h66;
    localparam logic [7:0] CH_N        = 8'h6E;

    typedef struct packed {
        t_kind kind;
        t_off  begin_off;
        t_off  finish_off;
    } t_token;

    // tokens caused by one text byte, in order
    typedef struct packed {
        t_token [2:0] tok;
        logic   [1:0] count;
    } t_run;

    function automatic logic is_num(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || c == CH_PLUS || c == CH_MINUS;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
    endfunction

    function automatic logic [2:0] word_len(input logic [1:0] cand);
        logic [2:0] len;
        case (cand)
            CAND_TRUE:  len = 3'd4;
            CAND_FALSE: len = 3'd5;
            CAND_NULL:  len = 3'd4;
            default:    len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] word_char(input logic [1:0] cand, input logic [2:0] idx);
        logic [7:0] ch;
        case ({cand, idx})
            {CAND_TRUE, 3'd0}:  ch = 8'h74;
            {CAND_TRUE, 3'd1}:  ch = 8'h72;
            {CAND_TRUE, 3'd2}:  ch = 8'h75;
            {CAND_TRUE, 3'd3}:  ch = 8'h65;
            {CAND_FALSE, 3'd0}: ch = 8'h66;
            {CAND_FALSE, 3'd1}: ch = 8'h61;
            {CAND_FALSE, 3'd2}: ch = 8'h6C;
            {CAND_FALSE, 3'd3}: ch = 8'h73;
            {CAND_FALSE, 3'd4}: ch = 8'h65;
            {CAND_NULL, 3'd0}:  ch = 8'h6E;
            {CAND_NULL, 3'd1}:  ch = 8'h75;
            {CAND_NULL, 3'd2}:  ch = 8'h6C;
            {CAND_NULL, 3'd3}:  ch = 8'h6C;
            default:            ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

FILE: rtl/jts_scan.sv
// ----------------------------------------------------------------------------
// jts_scan
// Scan state registers and the per-byte step that yields up to three tokens.
// ----------------------------------------------------------------------------
module jts_scan (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_text_byte,
    input  logic          i_final_byte,
    output jts_pkg::t_run o_run
);
    import jts_pkg::*;

    logic [2:0] r_mode, n_mode;
    t_off       r_pos, n_pos;
    t_off       r_pstart, n_pstart;
    logic [1:0] r_cand, n_cand;
    logic [2:0] r_widx, n_widx;
    logic       r_wmis, n_wmis;

    t_off   w_nxt, w_prev;
    t_run   w_run;
    logic   w_idle;

    // append a token unless three are already queued
    function automatic t_run put(input t_run r, input t_kind k, input t_off b, input t_off f);
        t_run q;
        q = r;
        if (q.count != 2'd3) begin
            q.tok[q.count] = '{kind: k, begin_off: b, finish_off: f};
            q.count        = q.count + 2'd1;
        end
        return q;
    endfunction

    function automatic t_kind word_kind(input logic [1:0] cand, input logic [2:0] idx,
                                        input logic mis);
        t_kind k;
        k = K_UNKNOWN;
        if (!mis && cand != CAND_NONE && idx == word_len(cand))
            k = (cand == CAND_NULL) ? K_NULL : K_BOOL;
        return k;
    endfunction

    assign w_nxt  = (r_pos == OFF_MAX) ? r_pos : r_pos + t_off'(1);
    assign w_prev = (r_pos == '0) ? r_pos : r_pos - t_off'(1);

    always_comb begin
        n_mode   = r_mode;
        n_pos    = w_nxt;
        n_pstart = r_pstart;
        n_cand   = r_cand;
        n_widx   = r_widx;
        n_wmis   = r_wmis;
        w_run    = '0;
        w_idle   = 1'b0;

        case (r_mode)
            MODE_INT, MODE_FRAC: begin
                if (!is_num(i_text_byte)) begin
                    if (i_text_byte == CH_DOT && r_mode == MODE_INT) begin
                        n_mode = MODE_DOT;
                    end else if (i_text_byte == CH_E) begin
                        n_mode = MODE_EXP;
                    end else begin
                        w_run  = put(w_run, K_NUMBER, r_pstart, r_pos);
                        w_idle = 1'b1;
                    end
                end
            end
            MODE_DOT: begin
                if (is_num(i_text_byte)) begin
                    n_mode = MODE_FRAC;
                end else begin
                    w_run  = put(w_run, K_NUMBER, r_pstart, w_prev);
                    w_run  = put(w_run, K_DOT, w_prev, r_pos);
                    w_idle = 1'b1;
                end
            end
            MODE_EXP: begin
                if (!is_num(i_text_byte)) begin
                    w_run  = put(w_run, K_NUMBER, r_pstart, r_pos);
                    w_idle = 1'b1;
                end
            end
            MODE_STR: begin
                if (i_text_byte == CH_BSLASH) begin
                    n_mode = MODE_ESC;
                end else if (i_text_byte == CH_QUOTE) begin
                    w_run  = put(w_run, K_STRING, r_pstart, w_nxt);
                    n_mode = MODE_IDLE;
                end
            end
            MODE_ESC: begin
                n_mode = MODE_STR;
            end
            MODE_WORD: begin
                if (is_letter(i_text_byte)) begin
                    if (!r_wmis && (r_cand == CAND_NONE || r_widx >= word_len(r_cand) ||
                                    i_text_byte != word_char(r_cand, r_widx)))
                        n_wmis = 1'b1;
                    if (r_widx != 3'd7)
                        n_widx = r_widx + 3'd1;
                end else begin
                    w_run  = put(w_run, word_kind(r_cand, r_widx, r_wmis), r_pstart, r_pos);
                    w_idle = 1'b1;
                end
            end
            default: begin
                w_idle = 1'b1;
            end
        endcase

        // byte seen from between tokens
        if (w_idle) begin
            n_mode = MODE_IDLE;
            case (i_text_byte)
                CH_LBRACE:   w_run = put(w_run, K_LBRACE, r_pos, w_nxt);
                CH_RBRACE:   w_run = put(w_run, K_RBRACE, r_pos, w_nxt);
                CH_COLON:    w_run = put(w_run, K_COLON, r_pos, w_nxt);
                CH_COMMA:    w_run = put(w_run, K_COMMA, r_pos, w_nxt);
                CH_DOT:      w_run = put(w_run, K_DOT, r_pos, w_nxt);
                CH_LBRACKET: w_run = put(w_run, K_LBRACKET, r_pos, w_nxt);
                CH_RBRACKET: w_run = put(w_run, K_RBRACKET, r_pos, w_nxt);
                CH_QUOTE: begin
                    n_mode   = MODE_STR;
                    n_pstart = r_pos;
                end
                CH_SP, CH_LF, CH_TAB, CH_CR: begin
                end
                default: begin
                    if (is_num(i_text_byte)) begin
                        n_mode   = MODE_INT;
                        n_pstart = r_pos;
                    end else if (is_letter(i_text_byte)) begin
                        n_mode   = MODE_WORD;
                        n_pstart = r_pos;
                        n_cand   = (i_text_byte == CH_T) ? CAND_TRUE :
                                   (i_text_byte == CH_F) ? CAND_FALSE :
                                   (i_text_byte == CH_N) ? CAND_NULL : CAND_NONE;
                        n_wmis   = (n_cand == CAND_NONE);
                        n_widx   = 3'd1;
                    end else begin
                        w_run = put(w_run, K_BADCHAR, r_pos, w_nxt);
                    end
                end
            endcase
        end

        // flush the open token and start a new text
        if (i_final_byte) begin
            case (n_mode)
                MODE_INT, MODE_FRAC, MODE_EXP: begin
                    w_run = put(w_run, K_NUMBER, n_pstart, w_nxt);
                end
                MODE_DOT: begin
                    w_run = put(w_run, K_NUMBER, n_pstart, r_pos);
                    w_run = put(w_run, K_DOT, r_pos, w_nxt);
                end
                MODE_STR, MODE_ESC: begin
                    w_run = put(w_run, K_UNTERM, n_pstart, w_nxt);
                end
                MODE_WORD: begin
                    w_run = put(w_run, word_kind(n_cand, n_widx, n_wmis), n_pstart, w_nxt);
                end
                default: begin
                end
            endcase
            n_mode   = MODE_IDLE;
            n_pos    = '0;
            n_pstart = '0;
            n_cand   = CAND_NONE;
            n_widx   = 3'd0;
            n_wmis   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_pos    <= '0;
            r_pstart <= '0;
            r_cand   <= CAND_NONE;
            r_widx   <= 3'd0;
            r_wmis   <= 1'b0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_pstart <= n_pstart;
            r_cand   <= n_cand;
            r_widx   <= n_widx;
            r_wmis   <= n_wmis;
        end
    end

    assign o_run = w_run;

endmodule

FILE: rtl/jts_outbuf.sv
// ----------------------------------------------------------------------------
// jts_outbuf
// Result register for the tokens of one byte; drains them one beat at a time.
// ----------------------------------------------------------------------------
module jts_outbuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  jts_pkg::t_run       i_run,
    output logic                o_room,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output jts_pkg::t_token     o_token,
    output logic                o_last_of_run
);
    import jts_pkg::*;

    logic [1:0]   r_cnt;
    logic [1:0]   r_idx;
    t_token [2:0] r_tok;
    logic         w_beat;
    logic         w_last;

    assign o_out_valid   = (r_cnt != 2'd0);
    assign w_last        = (r_idx == r_cnt - 2'd1);
    assign w_beat        = o_out_valid && !i_out_stall;
    assign o_room        = !o_out_valid || (w_beat && w_last);
    assign o_token       = r_tok[r_idx];
    assign o_last_of_run = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_run.count;
            r_idx <= 2'd0;
        end else if (w_beat) begin
            if (w_last) begin
                r_cnt <= 2'd0;
                r_idx <= 2'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tok <= i_run.tok;
        end
    end

    // read pointer always names a filled entry
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_idx < r_cnt))
        else $error("read index past filled entries");

    // a beat that is not the last of its run leaves more to deliver
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_beat && !w_last) |=> (o_out_valid && r_idx == $past(r_idx) + 2'd1))
        else $error("run ended early");

    // a load that carries tokens presents them on the next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && i_run.count != 2'd0) |=> (o_out_valid && r_idx == 2'd0))
        else $error("loaded tokens not presented");

    // no load may overwrite tokens still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_room)
        else $error("load while tokens pending");

    // reset empties the buffer
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("buffer not empty after reset");

endmodule

FILE: rtl/json_token_scanner.sv
// ----------------------------------------------------------------------------
// json_token_scanner
// Streaming JSON tokenizer: one text byte in per beat, tokens out per beat.
// ----------------------------------------------------------------------------
// Input channel: i_text_byte with i_final_byte, qualified by i_in_valid and
// held off by o_in_stall. Set i_final_byte on the last byte of a text; it
// flushes any open token (an open string comes out as an unterminated-string
// token) and the next byte starts a new text at offset 0.
// Output channel: o_token_kind, o_token_begin, o_token_finish, o_last_of_run,
// qualified by o_out_valid and held off by i_out_stall. o_last_of_run marks
// the final token caused by one input byte.
// Tokens of a byte are registered and appear in the cycle after that byte's beat.
// Throughput: one byte per cycle while each byte causes at most one token
// and the output is not stalled; a byte causing k tokens (k up to 3) holds
// the input stalled until its last token is being taken, set by the single
// output beat per cycle drained from the result register.
// Stall: while i_out_stall is high the current token holds; the input is
// stalled until the last token of the waiting run is being taken, so the
// next byte's beat overlaps that final output beat.
// Reset (synchronous, i_rst_n low): scanner goes idle, offset returns to 0,
// the result register empties.
// ----------------------------------------------------------------------------
module json_token_scanner (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [7:0]                 i_text_byte,
    input  logic                       i_final_byte,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [3:0]                 o_token_kind,
    output logic [jts_pkg::OFFSET_BITS-1:0] o_token_begin,
    output logic [jts_pkg::OFFSET_BITS-1:0] o_token_finish,
    output logic                       o_last_of_run
);
    import jts_pkg::*;

    logic   w_room;
    logic   w_accept;
    t_run   w_run;
    t_token w_token;

    // take a byte whenever the result register is free or freeing this cycle
    assign o_in_stall = !w_room;
    assign w_accept   = i_in_valid && w_room;

    jts_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_text_byte  (i_text_byte),
        .i_final_byte (i_final_byte),
        .o_run        (w_run)
    );

    jts_outbuf u_outbuf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_accept),
        .i_run         (w_run),
        .o_room        (w_room),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_token       (w_token),
        .o_last_of_run (o_last_of_run)
    );

    assign o_token_kind   = w_token.kind;
    assign o_token_begin  = w_token.begin_off;
    assign o_token_finish = w_token.finish_off;

endmodule
